[design/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg
// Types and constants shared by the sprite frame sequencer modules.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int unsigned ACC_W   = 25;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned FNUM_W  = 8;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 24;

  localparam logic [23:0] DEF_DUR_RESET = 24'd100000;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_RESTART = 2'd1;
  localparam logic [1:0] FUNC_SETF    = 2'd2;
  localparam logic [1:0] FUNC_WRITE   = 2'd3;

  localparam logic [2:0] MODE_LOOP     = 3'd0;
  localparam logic [2:0] MODE_ONCE     = 3'd1;
  localparam logic [2:0] MODE_REV      = 3'd2;
  localparam logic [2:0] MODE_REV_ONCE = 3'd3;
  localparam logic [2:0] MODE_PING     = 3'd4;

  localparam logic [CFG_A_W-1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_PLAY_MODE   = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_PAUSED      = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_DEF_DUR     = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [19:0]        delta_us;
    logic [7:0]         frame_number;
    logic [4:0]         entry_index;
    logic [23:0]        entry_duration_us;
    logic [15:0]        entry_image;
    logic signed [15:0] entry_offset_x;
    logic signed [15:0] entry_offset_y;
  } sfs_in_t;

  typedef struct packed {
    logic               active;
    logic [4:0]         frame_pos;
    logic [15:0]        image_index;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic               finished;
  } sfs_out_t;

  typedef struct packed {
    logic [23:0]        dur;
    logic [15:0]        image;
    logic signed [15:0] ofs_x;
    logic signed [15:0] ofs_y;
  } sfs_entry_t;

  localparam int unsigned ENTRY_W = $bits(sfs_entry_t);

endpackage

[design/sfs_frame_mem.sv]
// ----------------------------------------------------------------------------
// sfs_frame_mem
// Frame table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfs_frame_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 72
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/sfs_cmp_sub.sv]
// ----------------------------------------------------------------------------
// sfs_cmp_sub
// Shared compare-and-subtract unit used for frame timing and remainders.
// ----------------------------------------------------------------------------
module sfs_cmp_sub (
  input  logic [sfs_pkg::ACC_W-1:0] a_i,
  input  logic [sfs_pkg::ACC_W-1:0] b_i,
  output logic                      ge_o,
  output logic [sfs_pkg::ACC_W-1:0] diff_o
);
  import sfs_pkg::*;

  logic [ACC_W:0] sub;

  assign sub    = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o   = ~sub[ACC_W];
  assign diff_o = sub[ACC_W-1:0];

endmodule

[design/sprite_frame_sequencer.sv]
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Every accepted beat ends with S_RD (table read), S_EVAL and S_OUT; a tick
// returns to S_RD per frame advance, and a loop wrap, a set frame and the
// remainder in modes 5 to 7 use the divider in S_DIV. in_stall_o holds off a
// new beat until S_OUT registers the result beat; the shared compare-subtract
// unit does both frame timing and division. Async active-low reset clears
// control state and config; the frame table is undefined until written.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer #(
  parameter int unsigned MAX_FRAMES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sfs_pkg::sfs_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sfs_pkg::sfs_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sfs_pkg::CFG_A_W-1:0] cfg_index_i,
  input  logic [sfs_pkg::CFG_D_W-1:0] cfg_data_i
);
  import sfs_pkg::*;

  localparam int unsigned PW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned NW = $clog2(MAX_FRAMES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [ACC_W-1:0] elapsed_q, elapsed_d;
  logic             back_q, back_d;
  logic             done_q, done_d;
  logic             tick_run_q, tick_run_d;
  logic             out_valid_q, out_valid_d;
  sfs_out_t         out_data_q, out_data_d;

  logic [5:0]       frame_count_q;
  logic [2:0]       play_mode_q;
  logic             paused_q;
  logic [23:0]      def_dur_q;

  logic [ACC_W-1:0] div_rem_q, div_rem_d;
  logic [ACC_W-1:0] div_num_q, div_num_d;
  logic [ACC_W-1:0] div_dsr_q, div_dsr_d;
  logic [CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic             div_pos_q, div_pos_d;

  logic             in_acc;
  logic [NW-1:0]    count;
  logic [NW-1:0]    pos_w;
  logic [NW-1:0]    pos_inc;
  logic [23:0]      dur;

  logic [ACC_W-1:0] cmp_a, cmp_b, cmp_diff;
  logic             cmp_ge;
  logic [ACC_W-1:0] div_step;

  logic             mem_we, mem_re;
  logic [PW-1:0]    mem_waddr;
  sfs_entry_t       mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  sfs_entry_t       rd_entry;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign count = (32'(frame_count_q) > 32'(MAX_FRAMES)) ? NW'(MAX_FRAMES)
                                                         : NW'(frame_count_q);
  assign pos_w   = NW'(pos_q);
  assign pos_inc = pos_w + NW'(1);

  assign rd_entry = sfs_entry_t'(mem_rdata);
  assign dur = (rd_entry.dur != 24'd0) ? rd_entry.dur :
               (def_dur_q != 24'd0)    ? def_dur_q : 24'd1;

  assign div_step = {div_rem_q[ACC_W-2:0], div_num_q[ACC_W-1]};

  assign mem_waddr = PW'(in_data_i.entry_index);
  assign mem_wdata = '{dur:   in_data_i.entry_duration_us,
                       image: in_data_i.entry_image,
                       ofs_x: in_data_i.entry_offset_x,
                       ofs_y: in_data_i.entry_offset_y};

  sfs_frame_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (PW),
    .DW    (ENTRY_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (pos_q),
    .rdata_o (mem_rdata)
  );

  sfs_cmp_sub u_cmp (
    .a_i    (cmp_a),
    .b_i    (cmp_b),
    .ge_o   (cmp_ge),
    .diff_o (cmp_diff)
  );

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    elapsed_d   = elapsed_q;
    back_d      = back_q;
    done_d      = done_q;
    tick_run_d  = tick_run_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    div_rem_d   = div_rem_q;
    div_num_d   = div_num_q;
    div_dsr_d   = div_dsr_q;
    div_cnt_d   = div_cnt_q;
    div_pos_d   = div_pos_q;
    cmp_a       = div_step;
    cmp_b       = div_dsr_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RD;
          case (in_data_i.func)
            FUNC_TICK: begin
              if (count != '0 && !paused_q && !done_q) begin
                elapsed_d  = elapsed_q + ACC_W'(in_data_i.delta_us);
                tick_run_d = 1'b1;
              end
            end
            FUNC_RESTART: begin
              pos_d     = '0;
              elapsed_d = '0;
              back_d    = 1'b0;
              done_d    = 1'b0;
            end
            FUNC_SETF: begin
              if (count != '0) begin
                div_rem_d = '0;
                div_num_d = ACC_W'(in_data_i.frame_number) << (ACC_W - FNUM_W);
                div_dsr_d = ACC_W'(count);
                div_cnt_d = CNT_W'(FNUM_W);
                div_pos_d = 1'b1;
                state_d   = S_DIV;
              end
            end
            FUNC_WRITE: begin
              mem_we = (32'(in_data_i.entry_index) < 32'(MAX_FRAMES));
            end
            default: begin
            end
          endcase
        end
      end

      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_EVAL;
      end

      S_EVAL: begin
        cmp_a = elapsed_q;
        cmp_b = ACC_W'(dur);
        if (!tick_run_q || done_q) begin
          tick_run_d = 1'b0;
          state_d    = S_OUT;
        end else if (play_mode_q > MODE_PING) begin
          div_rem_d = '0;
          div_num_d = elapsed_q;
          div_dsr_d = ACC_W'(dur);
          div_cnt_d = CNT_W'(ACC_W);
          div_pos_d = 1'b0;
          state_d   = S_DIV;
        end else if (cmp_ge) begin
          elapsed_d = cmp_diff;
          state_d   = S_RD;
          case (play_mode_q)
            MODE_LOOP: begin
              if (pos_inc < count) begin
                pos_d = PW'(pos_inc);
              end else begin
                div_rem_d = '0;
                div_num_d = ACC_W'(pos_inc) << (ACC_W - NW);
                div_dsr_d = ACC_W'(count);
                div_cnt_d = CNT_W'(NW);
                div_pos_d = 1'b1;
                state_d   = S_DIV;
              end
            end
            MODE_ONCE: begin
              if (pos_inc < count) begin
                pos_d = PW'(pos_inc);
              end else begin
                done_d = 1'b1;
              end
            end
            MODE_REV: begin
              pos_d = (pos_w == '0) ? PW'(count - NW'(1)) : PW'(pos_w - NW'(1));
            end
            MODE_REV_ONCE: begin
              if (pos_w != '0) begin
                pos_d = PW'(pos_w - NW'(1));
              end else begin
                done_d = 1'b1;
              end
            end
            MODE_PING: begin
              if (!back_q) begin
                if (pos_inc >= count) begin
                  back_d = 1'b1;
                  pos_d  = (count >= NW'(2)) ? PW'(count - NW'(2)) : '0;
                end else begin
                  pos_d = PW'(pos_inc);
                end
              end else begin
                if (pos_w == '0) begin
                  back_d = 1'b0;
                  pos_d  = (count > NW'(1)) ? PW'(1) : '0;
                end else begin
                  pos_d = PW'(pos_w - NW'(1));
                end
              end
            end
            default: begin
            end
          endcase
        end else begin
          tick_run_d = 1'b0;
          state_d    = S_OUT;
        end
      end

      S_DIV: begin
        div_rem_d = cmp_ge ? cmp_diff : div_step;
        div_num_d = div_num_q << 1;
        div_cnt_d = div_cnt_q - CNT_W'(1);
        if (div_cnt_q == CNT_W'(1)) begin
          if (div_pos_q) begin
            pos_d   = PW'(div_rem_d);
            state_d = S_RD;
          end else begin
            elapsed_d  = div_rem_d;
            tick_run_d = 1'b0;
            state_d    = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (count == '0) begin
            out_data_d = '0;
          end else begin
            out_data_d = '{active:      1'b1,
                           frame_pos:   5'(pos_q),
                           image_index: rd_entry.image,
                           offset_x:    rd_entry.ofs_x,
                           offset_y:    rd_entry.ofs_y,
                           finished:    done_q};
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      elapsed_q   <= '0;
      back_q      <= 1'b0;
      done_q      <= 1'b0;
      tick_run_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      elapsed_q   <= elapsed_d;
      back_q      <= back_d;
      done_q      <= done_d;
      tick_run_q  <= tick_run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    div_rem_q  <= div_rem_d;
    div_num_q  <= div_num_d;
    div_dsr_q  <= div_dsr_d;
    div_cnt_q  <= div_cnt_d;
    div_pos_q  <= div_pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= '0;
      play_mode_q   <= MODE_LOOP;
      paused_q      <= 1'b0;
      def_dur_q     <= DEF_DUR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_COUNT: frame_count_q <= cfg_data_i[5:0];
        CFG_PLAY_MODE:   play_mode_q   <= cfg_data_i[2:0];
        CFG_PAUSED:      paused_q      <= cfg_data_i[0];
        CFG_DEF_DUR:     def_dur_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule
